// File: rtl/pmes_pkg.sv
// ----------------------------------------------------------------------------
// pmes_pkg
// Shared types and constants for the multichannel PWM event scheduler.
// ----------------------------------------------------------------------------
package pmes_pkg;

  localparam int unsigned TICK_CLOCK = 80000000;
  localparam int unsigned MIN_LOAD   = 500;
  localparam int unsigned MAX_LOAD   = 8000000;
  localparam int unsigned FREQ_LOW   = 10;
  localparam int unsigned FREQ_HIGH  = 10000;
  localparam int unsigned DUTY_FULL  = 10000;

  localparam int TICK_W  = 23;  // phase lengths, reload
  localparam int CNT_W   = 24;  // signed countdown
  localparam int DIVD_W  = 37;  // dividend: period * duty + rounding
  localparam int DIVS_W  = 16;  // divisor: frequency
  localparam int DSTEP_W = 6;   // divider step counter

  // divide by DUTY_FULL as a shift by 4, then a reciprocal multiply for 625;
  // ceil(2^43 / 625) is exact for quotients of dividends below 2^33
  localparam int QSH_W  = DIVD_W - 4;
  localparam int RCP_W  = 17;              // reciprocal slice, two per multiply
  localparam int PART_W = QSH_W + RCP_W;
  localparam int RSUM_W = PART_W + RCP_W;
  localparam int RSHIFT = 43;
  localparam logic [2*RCP_W-1:0] RECIP_625 = 34'd14073748836;

  typedef struct packed {
    logic        kind;
    logic [2:0]  channel;
    logic [15:0] freq_hz;
    logic [13:0] duty_centi;
  } pmes_in_t;

  typedef struct packed {
    logic              accepted;
    logic [7:0]        set_mask;
    logic [7:0]        clear_mask;
    logic [7:0]        level_mask;
    logic [TICK_W-1:0] reload_ticks;
    logic              reload_changed;
    logic              timer_running;
  } pmes_out_t;

  // token walking down the cell row on a timer tick
  typedef struct packed {
    logic              valid;
    logic [TICK_W-1:0] run_min;
  } pmes_tok_t;

  // channel write command, broadcast to all cells
  typedef struct packed {
    logic              wr;
    logic [TICK_W-1:0] high;
    logic [TICK_W-1:0] low;
  } pmes_cmd_t;

  // per-cell status back to the controller
  typedef struct packed {
    logic same;
    logic level;
    logic set_ev;
    logic clr_ev;
  } pmes_cst_t;

endpackage

// File: rtl/pmes_div.sv
// ----------------------------------------------------------------------------
// pmes_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pmes_div import pmes_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIVD_W-1:0] dividend,
  input  logic [DIVS_W-1:0] divisor,
  output logic              done,
  output logic [DIVD_W-1:0] quotient
);

  logic              busy;
  logic [DSTEP_W-1:0] step;
  logic [DIVD_W-1:0] dq;
  logic [DIVS_W-1:0] rem;
  logic [DIVS_W-1:0] dvs;
  logic [DIVS_W:0]   trial;
  logic [DIVS_W:0]   diff;
  logic              ge;

  assign trial    = {rem, dq[DIVD_W-1]};
  assign ge       = trial >= {1'b0, dvs};
  assign diff     = trial - {1'b0, dvs};
  assign quotient = dq;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        dq   <= dividend;
        rem  <= '0;
        dvs  <= divisor;
      end else if (busy) begin
        rem  <= ge ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
        dq   <= {dq[DIVD_W-2:0], ge};
        step <= step + 1'b1;
        if (step == DSTEP_W'(DIVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// File: rtl/pmes_cell.sv
// ----------------------------------------------------------------------------
// pmes_cell
// One PWM channel: phase lengths, level, countdown; takes writes, updates when
// the tick token passes and hands the running minimum to the next cell.
// ----------------------------------------------------------------------------
module pmes_cell import pmes_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              sel,
  input  pmes_cmd_t         cmd,
  input  logic [TICK_W-1:0] prev,
  input  pmes_tok_t         tok_in,
  output pmes_tok_t         tok_out,
  output pmes_cst_t         st
);

  logic [TICK_W-1:0]       high;
  logic [TICK_W-1:0]       low;
  logic                    level;
  logic signed [CNT_W-1:0] cnt;
  logic                    set_ev;
  logic                    clr_ev;

  logic                    active;
  logic                    take;
  logic                    hit;
  logic                    same;
  logic signed [CNT_W-1:0] diff;
  logic signed [CNT_W-1:0] cnt_next;
  logic [TICK_W-1:0]       min_next;

  assign active = (high != '0) && (low != '0);
  assign take   = tok_in.valid && active;
  assign diff   = cnt - $signed({1'b0, prev});
  assign hit    = diff <= $signed(CNT_W'(MIN_LOAD));
  assign same   = (high == cmd.high) && (low == cmd.low);

  always_comb begin
    if (hit) begin
      cnt_next = level ? $signed({1'b0, low}) : $signed({1'b0, high});
    end else begin
      cnt_next = diff;
    end
    // an active count is always positive once updated
    if (take && (cnt_next[TICK_W-1:0] < tok_in.run_min)) begin
      min_next = cnt_next[TICK_W-1:0];
    end else begin
      min_next = tok_in.run_min;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      high    <= '0;
      low     <= '0;
      level   <= 1'b0;
      cnt     <= '0;
      set_ev  <= 1'b0;
      clr_ev  <= 1'b0;
      tok_out <= '0;
    end else begin
      tok_out.valid   <= tok_in.valid;
      tok_out.run_min <= min_next;
      set_ev          <= take && hit && !level;
      clr_ev          <= take && hit && level;
      if (cmd.wr && sel && !same) begin
        high  <= cmd.high;
        low   <= cmd.low;
        level <= 1'b0;
        cnt   <= $signed({1'b0, cmd.low});
      end else if (take) begin
        cnt <= cnt_next;
        if (hit) begin
          level <= !level;
        end
      end
    end
  end

  assign st.same   = same;
  assign st.level  = level;
  assign st.set_ev = set_ev;
  assign st.clr_ev = clr_ev;

endmodule

// File: rtl/multichannel_pwm_event_scheduler.sv
// ----------------------------------------------------------------------------
// multichannel_pwm_event_scheduler
// PWM channels sharing one down-counting base timer; set items program a
// channel, tick items advance all channels and pick the next reload.
// ----------------------------------------------------------------------------
// Tick beat: the token walks the cell row one channel per cycle and its running
//   minimum becomes the reload; the next beat is taken once back in idle.
// Set beat: the bit-serial period divide, then the duty product and a two-slice
//   reciprocal multiply for the high time, a clamp and the cell write.
// Rejected or ignored beats go straight to push. One beat in flight at a time; a
//   waiting result holds the next one in push. Reset: channels off, timer stopped.
module multichannel_pwm_event_scheduler import pmes_pkg::*; #(
  parameter int CHANNELS = 8
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_stall,
  input  pmes_in_t  item,
  output logic      result_valid,
  input  logic      result_stall,
  output pmes_out_t result
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DIV1   = 4'd1;
  localparam logic [3:0] S_MUL    = 4'd2;
  localparam logic [3:0] S_REC_LO = 4'd3;
  localparam logic [3:0] S_REC_HI = 4'd4;
  localparam logic [3:0] S_CLAMP  = 4'd5;
  localparam logic [3:0] S_WRITE  = 4'd6;
  localparam logic [3:0] S_TICK   = 4'd7;
  localparam logic [3:0] S_PUSH   = 4'd8;

  logic [3:0]          state;
  logic [2:0]          chan_reg;
  logic [13:0]         duty_reg;
  logic [TICK_W-1:0]   period;
  logic [DIVD_W-1:0]   prod;
  logic [PART_W-1:0]   racc;
  logic [CNT_W-1:0]    hq;
  logic [TICK_W-1:0]   th;
  logic [TICK_W-1:0]   tl;
  logic [TICK_W-1:0]   reload;
  logic                running;
  logic [CHANNELS-1:0] set_acc;
  logic [CHANNELS-1:0] clr_acc;
  pmes_tok_t           launch;
  logic                res_acc;
  logic [7:0]          res_set;
  logic [7:0]          res_clr;
  logic                res_changed;

  logic                accept;
  logic                set_ok;
  logic                div_start;
  logic [DIVD_W-1:0]   div_dividend;
  logic [DIVS_W-1:0]   div_divisor;
  logic                div_done;
  logic [DIVD_W-1:0]   div_quot;
  logic [QSH_W-1:0]    x16;
  logic [RCP_W-1:0]    rcp_coef;
  logic [PART_W-1:0]   part;
  logic [RSUM_W-1:0]   rsum;
  logic [CNT_W-1:0]    h_raw;
  logic [CNT_W-1:0]    h_hi;
  logic [CNT_W-1:0]    h_clamp;
  logic [TICK_W-1:0]   th_next;
  logic                same_sel;
  pmes_cmd_t           cmd;

  pmes_tok_t           tok_chain [CHANNELS+1];
  pmes_cst_t           st [CHANNELS];
  logic [CHANNELS-1:0] sel_vec;
  logic [CHANNELS-1:0] same_vec;
  logic [CHANNELS-1:0] level_vec;
  logic [CHANNELS-1:0] set_ev_vec;
  logic [CHANNELS-1:0] clr_ev_vec;
  logic [CHANNELS-1:0] cur_set;
  logic [CHANNELS-1:0] cur_clr;
  logic [7:0]          set8;
  logic [7:0]          clr8;
  logic [7:0]          lvl8;

  assign item_stall = (state != S_IDLE);
  assign accept     = item_valid && !item_stall;
  assign set_ok     = item.kind
                   && (32'(item.freq_hz) >= FREQ_LOW)
                   && (32'(item.freq_hz) <= FREQ_HIGH)
                   && (32'(item.channel) < CHANNELS);

  // divider computes the rounded period
  assign div_start    = accept && set_ok;
  assign div_dividend = DIVD_W'(TICK_CLOCK) + DIVD_W'(item.freq_hz >> 1);
  assign div_divisor  = item.freq_hz;

  pmes_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quot)
  );

  // high time: one multiplier, low reciprocal slice first, then the high one
  assign x16      = prod[DIVD_W-1:4];
  assign rcp_coef = (state == S_REC_HI) ? RECIP_625[2*RCP_W-1:RCP_W]
                                        : RECIP_625[RCP_W-1:0];
  assign part     = PART_W'(x16) * PART_W'(rcp_coef);
  assign rsum     = RSUM_W'(racc) + {part, {RCP_W{1'b0}}};

  // clamp high time to [500, period - 500]
  assign h_raw = hq;
  assign h_hi  = {1'b0, period} - CNT_W'(MIN_LOAD);

  always_comb begin
    if (h_raw < CNT_W'(MIN_LOAD)) begin
      h_clamp = CNT_W'(MIN_LOAD);
    end else if (h_raw > h_hi) begin
      h_clamp = h_hi;
    end else begin
      h_clamp = h_raw;
    end
  end

  assign th_next = h_clamp[TICK_W-1:0];

  assign cmd.wr   = (state == S_WRITE);
  assign cmd.high = th;
  assign cmd.low  = tl;

  assign tok_chain[0] = launch;

  genvar i;
  generate
    for (i = 0; i < CHANNELS; i++) begin : g_cell
      assign sel_vec[i]    = (32'(chan_reg) == i);
      assign same_vec[i]   = st[i].same;
      assign level_vec[i]  = st[i].level;
      assign set_ev_vec[i] = st[i].set_ev;
      assign clr_ev_vec[i] = st[i].clr_ev;

      pmes_cell u_cell (
        .clk     (clk),
        .rst     (rst),
        .sel     (sel_vec[i]),
        .cmd     (cmd),
        .prev    (reload),
        .tok_in  (tok_chain[i]),
        .tok_out (tok_chain[i+1]),
        .st      (st[i])
      );
    end
  endgenerate

  assign same_sel = |(sel_vec & same_vec);

  always_comb begin
    if (state == S_WRITE) begin
      cur_set = '0;
      cur_clr = sel_vec & ~same_vec;
    end else begin
      cur_set = set_acc | set_ev_vec;
      cur_clr = clr_acc | clr_ev_vec;
    end
  end

  // reported masks cover the low eight channels
  genvar k;
  generate
    for (k = 0; k < 8; k++) begin : g_mask
      if (k < CHANNELS) begin : g_on
        assign set8[k] = cur_set[k];
        assign clr8[k] = cur_clr[k];
        assign lvl8[k] = level_vec[k];
      end else begin : g_off
        assign set8[k] = 1'b0;
        assign clr8[k] = 1'b0;
        assign lvl8[k] = 1'b0;
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      reload       <= '0;
      running      <= 1'b0;
      launch       <= '0;
      set_acc      <= '0;
      clr_acc      <= '0;
      result_valid <= 1'b0;
    end else begin
      if ((state == S_PUSH) && (!result_valid || !result_stall)) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            chan_reg    <= item.channel;
            duty_reg    <= item.duty_centi;
            set_acc     <= '0;
            clr_acc     <= '0;
            res_acc     <= 1'b0;
            res_set     <= '0;
            res_clr     <= '0;
            res_changed <= 1'b0;
            if (set_ok) begin
              state <= S_DIV1;
            end else if (!item.kind && running) begin
              launch.valid   <= 1'b1;
              launch.run_min <= TICK_W'(MAX_LOAD);
              state          <= S_TICK;
            end else begin
              state <= S_PUSH;
            end
          end
        end
        S_DIV1: begin
          if (div_done) begin
            period <= div_quot[TICK_W-1:0];
            state  <= S_MUL;
          end
        end
        S_MUL: begin
          prod  <= DIVD_W'(period) * DIVD_W'(duty_reg) + DIVD_W'(DUTY_FULL / 2);
          state <= S_REC_LO;
        end
        S_REC_LO: begin
          racc  <= part;
          state <= S_REC_HI;
        end
        S_REC_HI: begin
          hq    <= rsum[RSHIFT+CNT_W-1:RSHIFT];
          state <= S_CLAMP;
        end
        S_CLAMP: begin
          th    <= th_next;
          tl    <= period - th_next;
          state <= S_WRITE;
        end
        S_WRITE: begin
          // cells take the write this cycle unless the setting is unchanged
          res_acc     <= 1'b1;
          res_set     <= set8;
          res_clr     <= clr8;
          res_changed <= !same_sel && !running;
          if (!same_sel && !running) begin
            running <= 1'b1;
            reload  <= TICK_W'(MIN_LOAD);
          end
          state <= S_PUSH;
        end
        S_TICK: begin
          launch.valid <= 1'b0;
          set_acc      <= cur_set;
          clr_acc      <= cur_clr;
          if (tok_chain[CHANNELS].valid) begin
            res_acc     <= 1'b1;
            res_set     <= set8;
            res_clr     <= clr8;
            res_changed <= (tok_chain[CHANNELS].run_min != reload);
            reload      <= tok_chain[CHANNELS].run_min;
            state       <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (!result_valid || !result_stall) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result payload, loaded when the beat leaves the push state
  always_ff @(posedge clk) begin
    if ((state == S_PUSH) && (!result_valid || !result_stall)) begin
      result.accepted       <= res_acc;
      result.set_mask       <= res_set;
      result.clear_mask     <= res_clr;
      result.level_mask     <= lvl8;
      result.reload_ticks   <= reload;
      result.reload_changed <= res_changed;
      result.timer_running  <= running;
    end
  end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the PWM event scheduler: directed set and tick
// beats, then random traffic, checked against a cycle-free channel model.
// ----------------------------------------------------------------------------
module tb;
  import pmes_pkg::*;

  localparam int CHANNELS       = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 2 * DIVD_W + CHANNELS + 20;
  localparam int RANDOM_ITEMS   = 1325;

  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_SET  = 1'b1;

  // signed copies so countdown compares stay signed
  localparam int MIN_PHASE  = int'(MIN_LOAD);
  localparam int RELOAD_CAP = int'(MAX_LOAD);

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      item_valid = 1'b0;
  logic      item_stall;
  pmes_in_t  item = '0;
  logic      result_valid;
  logic      result_stall = 1'b0;
  pmes_out_t result;

  // channel model state
  int unsigned      ch_high [CHANNELS];
  int unsigned      ch_low  [CHANNELS];
  int               ch_count[CHANNELS];
  logic [7:0]       ch_level;
  int               reload_now;
  logic             timer_on;

  pmes_out_t pwm_expected[$];
  int        fail_count  = 0;
  int        hold_cycles = 0;
  int        quiet_cycles = 0;
  bit        took_result = 1'b0;
  bit        idle_in  = 1'b1;
  bit        idle_out = 1'b1;

  multichannel_pwm_event_scheduler #(.CHANNELS(CHANNELS)) dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic pmes_in_t make_item(input logic kind, input int ch, input int freq,
                                         input int duty);
    pmes_in_t it;
    it.kind       = kind;
    it.channel    = ch[2:0];
    it.freq_hz    = freq[15:0];
    it.duty_centi = duty[13:0];
    return it;
  endfunction

  function automatic pmes_out_t pwm_predict(input pmes_in_t it);
    pmes_out_t        r;
    int unsigned      period;
    int unsigned      th;
    int unsigned      tl;
    longint unsigned  h;
    int               prev;
    int               nxt;
    int               c;
    r = '0;
    c = it.channel;
    if (it.kind == KIND_SET) begin
      if (it.freq_hz >= FREQ_LOW && it.freq_hz <= FREQ_HIGH) begin
        period = (TICK_CLOCK + 32'(it.freq_hz) / 2) / 32'(it.freq_hz);
        h = period;
        h = (h * it.duty_centi + DUTY_FULL / 2) / DUTY_FULL;
        if (h < MIN_LOAD) h = MIN_LOAD;
        if (h > period - MIN_LOAD) h = period - MIN_LOAD;
        th = int'(h);
        tl = period - th;
        r.accepted = 1'b1;
        if (!(ch_high[c] == th && ch_low[c] == tl)) begin
          // new setting: restart low phase
          ch_high[c]     = th;
          ch_low[c]      = tl;
          ch_level[c]    = 1'b0;
          ch_count[c]    = int'(tl);
          r.clear_mask[c] = 1'b1;
          if (!timer_on) begin
            timer_on         = 1'b1;
            reload_now       = MIN_PHASE;
            r.reload_changed = 1'b1;
          end
        end
      end
    end else if (timer_on) begin
      prev = reload_now;
      nxt  = RELOAD_CAP;
      for (int i = 0; i < CHANNELS; i++) begin
        if (ch_high[i] != 0 && ch_low[i] != 0) begin
          ch_count[i] -= prev;
          if (ch_count[i] <= MIN_PHASE) begin
            if (ch_level[i]) begin
              r.clear_mask[i] = 1'b1;
              ch_count[i]     = int'(ch_low[i]);
              ch_level[i]     = 1'b0;
            end else begin
              r.set_mask[i] = 1'b1;
              ch_count[i]   = int'(ch_high[i]);
              ch_level[i]   = 1'b1;
            end
          end
          if (ch_count[i] < nxt) nxt = ch_count[i];
        end
      end
      if (nxt < 0) nxt = 0;
      if (nxt != prev) begin
        reload_now       = nxt;
        r.reload_changed = 1'b1;
      end
      r.accepted = 1'b1;
    end
    r.level_mask    = ch_level;
    r.reload_ticks  = TICK_W'(reload_now);
    r.timer_running = timer_on;
    return r;
  endfunction

  // one input beat: optional gap, hold until accepted, then predict
  task automatic send_item(input pmes_in_t it);
    int unsigned gap;
    gap = idle_in ? $urandom_range(0, 3) : 0;
    @(negedge clk);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item       <= it;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    pwm_expected.push_back(pwm_predict(it));
  endtask

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : result_check
    pmes_out_t want;
    took_result = !rst && result_valid && !result_stall;
    if (took_result) begin
      if (pwm_expected.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, actual %h", $time, result);
        fail_count++;
      end else begin
        want = pwm_expected.pop_front();
        check_field("accepted",       want.accepted,       result.accepted);
        check_field("set_mask",       want.set_mask,       result.set_mask);
        check_field("clear_mask",     want.clear_mask,     result.clear_mask);
        check_field("level_mask",     want.level_mask,     result.level_mask);
        check_field("reload_ticks",   want.reload_ticks,   result.reload_ticks);
        check_field("reload_changed", want.reload_changed, result.reload_changed);
        check_field("timer_running",  want.timer_running,  result.timer_running);
      end
    end
  end

  // after each result beat, hold off the next one for a random count
  always @(negedge clk) begin
    if (took_result) begin
      hold_cycles = idle_out ? $urandom_range(0, 3) : 0;
    end
    if (hold_cycles > 0) begin
      result_stall <= 1'b1;
      hold_cycles--;
    end else begin
      result_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ns: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ticks and bad sets before any channel runs must not start the timer
  task automatic test_idle_timer();
    send_item(make_item(KIND_TICK, 0, 0, 0));
    send_item(make_item(KIND_SET, 3, 9, 5000));
    send_item(make_item(KIND_TICK, 7, 65535, 16383));
  endtask

  // long reload in force when a short channel is set: count goes negative
  task automatic test_overrun();
    send_item(make_item(KIND_SET, 0, FREQ_LOW, 5000));
    send_item(make_item(KIND_TICK, 0, 0, 0));
    send_item(make_item(KIND_SET, 1, FREQ_HIGH, 5000));
    send_item(make_item(KIND_TICK, 0, 0, 0));
  endtask

  task automatic test_freq_bounds();
    send_item(make_item(KIND_SET, 2, 0, 5000));
    send_item(make_item(KIND_SET, 2, FREQ_LOW - 1, 5000));
    send_item(make_item(KIND_SET, 2, FREQ_HIGH + 1, 5000));
    send_item(make_item(KIND_SET, 2, 65535, 5000));
    send_item(make_item(KIND_SET, 2, FREQ_LOW, 2500));
    send_item(make_item(KIND_SET, 4, FREQ_HIGH, 7500));
  endtask

  // duty at and beyond the ends; high time clamps both ways
  task automatic test_duty_clamp();
    send_item(make_item(KIND_SET, 5, 4000, 0));
    send_item(make_item(KIND_SET, 6, 4000, DUTY_FULL));
    send_item(make_item(KIND_SET, 7, 7000, 12000));
    send_item(make_item(KIND_SET, 3, 9999, 16383));
    send_item(make_item(KIND_SET, 5, 12345 % FREQ_HIGH, 8191));
  endtask

  task automatic test_setting_reuse();
    send_item(make_item(KIND_SET, 6, 4000, DUTY_FULL));
    send_item(make_item(KIND_SET, 6, 4000, 9990));
    send_item(make_item(KIND_SET, 6, 4000, 5000));
  endtask

  task automatic test_ticks();
    repeat (4) send_item(make_item(KIND_TICK, $urandom, $urandom, $urandom));
  endtask

  task automatic test_random_traffic(input int n_items);
    pmes_in_t last_set;
    pmes_in_t it;
    int       pick;
    int       freq_v;
    int       duty_v;
    last_set = make_item(KIND_SET, 0, 1000, 5000);
    for (int k = 0; k < n_items; k++) begin
      // alternate stretches with and without idling
      if (k % 64 == 0) begin
        idle_in  = ($urandom_range(0, 3) != 0);
        idle_out = ($urandom_range(0, 3) != 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 72) begin
        it = make_item(KIND_TICK, $urandom, $urandom, $urandom_range(0, DUTY_FULL));
      end else if (pick < 77) begin
        it = last_set;
      end else begin
        case ($urandom_range(0, 9))
          0:       freq_v = $urandom_range(0, 65535);
          1:       freq_v = $urandom_range(0, 1) ? FREQ_LOW : FREQ_HIGH;
          2, 3, 4: freq_v = $urandom_range(2000, FREQ_HIGH);
          default: freq_v = $urandom_range(FREQ_LOW, FREQ_HIGH);
        endcase
        case ($urandom_range(0, 7))
          0:       duty_v = 0;
          1:       duty_v = DUTY_FULL;
          2:       duty_v = $urandom_range(0, 16383);
          default: duty_v = $urandom_range(0, DUTY_FULL);
        endcase
        it       = make_item(KIND_SET, $urandom_range(0, CHANNELS - 1), freq_v, duty_v);
        last_set = it;
      end
      send_item(it);
    end
  endtask

  initial begin
    for (int i = 0; i < CHANNELS; i++) begin
      ch_high[i]  = 0;
      ch_low[i]   = 0;
      ch_count[i] = 0;
    end
    ch_level   = '0;
    reload_now = 0;
    timer_on   = 1'b0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_idle_timer();
    test_overrun();
    test_freq_bounds();
    test_duty_clamp();
    test_setting_reuse();
    test_ticks();
    test_random_traffic(RANDOM_ITEMS);

    @(negedge clk);
    item_valid <= 1'b0;
    while (pwm_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/pmes_pkg.sv
rtl/pmes_div.sv
rtl/pmes_cell.sv
rtl/multichannel_pwm_event_scheduler.sv
tb/tb.sv
